[sv/sliding_median_filter_core_defines.svh]
// Assertion macros used by the sliding median filter datapath.
`ifndef SLIDING_MEDIAN_FILTER_CORE_DEFINES_SVH
`define SLIDING_MEDIAN_FILTER_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SMF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/smf_pkg.sv]
// Shared types, constants and the microcode table of the sliding median filter.
package smf_pkg;

    localparam int MAX_WINDOW_DEF = 16;
    localparam int SAMPLE_W       = 32;
    localparam int HELD_W         = 5;
    localparam int WIN_CFG_W      = 8;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 40;
    localparam int TDATA_PAD_W    = OUT_TDATA_W - SAMPLE_W - HELD_W;

    localparam logic [WIN_CFG_W-1:0] WIN_FALLBACK = 8'd3;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t STEP_IDLE    = 4'd0;
    localparam upc_t STEP_APPLY   = 4'd1;
    localparam upc_t STEP_WRAP    = 4'd2;
    localparam upc_t STEP_CAND    = 4'd3;
    localparam upc_t STEP_FIRST   = 4'd4;
    localparam upc_t STEP_COUNT   = 4'd5;
    localparam upc_t STEP_SELECT  = 4'd6;
    localparam upc_t STEP_AVERAGE = 4'd7;
    localparam upc_t STEP_OUTPUT  = 4'd8;
    localparam upc_t STEP_RETURN  = 4'd9;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_IDLE,
        DP_APPLY,
        DP_WRAP,
        DP_CAND,
        DP_FIRST,
        DP_COUNT,
        DP_SELECT,
        DP_AVERAGE,
        DP_OUTPUT
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_IS_CLEAR,
        COND_WP_GE_WIN,
        COND_J_LT_N,
        COND_I_MORE,
        COND_OUT_WAIT
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic is_clear;
        logic wp_ge_win;
        logic j_lt_n;
        logic i_more;
    } dp_status_t;

    // Each step jumps to its target when its condition is true, else falls through.
    function automatic ctrl_word_t ucode_rom(input upc_t step);
        ctrl_word_t w;
        unique case (step)
            STEP_IDLE:    w = '{op: DP_IDLE,    cond: COND_NO_IN,     target: STEP_IDLE};
            STEP_APPLY:   w = '{op: DP_APPLY,   cond: COND_IS_CLEAR,  target: STEP_OUTPUT};
            STEP_WRAP:    w = '{op: DP_WRAP,    cond: COND_WP_GE_WIN, target: STEP_WRAP};
            STEP_CAND:    w = '{op: DP_CAND,    cond: COND_NEVER,     target: STEP_IDLE};
            STEP_FIRST:   w = '{op: DP_FIRST,   cond: COND_NEVER,     target: STEP_IDLE};
            STEP_COUNT:   w = '{op: DP_COUNT,   cond: COND_J_LT_N,    target: STEP_COUNT};
            STEP_SELECT:  w = '{op: DP_SELECT,  cond: COND_I_MORE,    target: STEP_CAND};
            STEP_AVERAGE: w = '{op: DP_AVERAGE, cond: COND_NEVER,     target: STEP_IDLE};
            STEP_OUTPUT:  w = '{op: DP_OUTPUT,  cond: COND_OUT_WAIT,  target: STEP_OUTPUT};
            STEP_RETURN:  w = '{op: DP_NOP,     cond: COND_ALWAYS,    target: STEP_IDLE};
            default:      w = '{op: DP_NOP,     cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

[sv/sliding_median_filter_core.sv]
// A push writes its sample, wraps the write position into the window, then for each held
// entry reads it as a candidate and counts its rank, averages the two middle values and
// offers the result. A clear empties the history and offers its result without those steps.
// One item at a time: the next input is taken only after the output transfer.
// The rank-counting loop makes two compares per cycle on the dual-read history.
// Reset empties the history through its valid bits at once and sets the window to 3.
module sliding_median_filter_core
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [WIN_CFG_W-1:0]   cfg_wr_data,   // window length
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] sample
    input  logic                   s_axis_tuser,  // [0] operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [31:0] median_value, [36:32] samples_held
);

    localparam int AW = $clog2(MAX_WINDOW);

    logic [WIN_CFG_W-1:0]   win_len_reg;
    ctrl_word_t             ctrl;
    dp_status_t             status;
    logic                   in_fire;
    logic                   out_fire;
    logic                   wr_en;
    logic                   clr_all;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_W-1:0]    wr_data;
    logic [AW-1:0]          rd_addr_a;
    logic [AW-1:0]          rd_addr_b;
    logic [SAMPLE_W-1:0]    rd_data_a;
    logic [SAMPLE_W-1:0]    rd_data_b;
    logic [SAMPLE_W-1:0]    median_value;
    logic [HELD_W-1:0]      samples_held;
    logic [TDATA_PAD_W-1:0] tdata_pad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WIN_FALLBACK;
        end
        else if (cfg_wr_en)
        begin
            win_len_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = ctrl.op == DP_IDLE;
    assign m_axis_tvalid = ctrl.op == DP_OUTPUT;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign tdata_pad     = '0;
    assign m_axis_tdata  = {tdata_pad, samples_held, median_value};

    smf_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .status   (status),
        .ctrl     (ctrl)
    );

    smf_hist #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_all   (clr_all),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    smf_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .in_fire      (in_fire),
        .in_op        (s_axis_tuser),
        .in_sample    (s_axis_tdata),
        .win_len_cfg  (win_len_reg),
        .rd_data_a    (rd_data_a),
        .rd_data_b    (rd_data_b),
        .status       (status),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .clr_all      (clr_all),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .median_value (median_value),
        .samples_held (samples_held)
    );

endmodule

[sv/smf_hist.sv]
// Sample history memory with per-entry valid bits and two registered read ports.
module smf_hist
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr_all,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
    input  logic [SAMPLE_W-1:0]           wr_data,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_addr_a,
    input  logic [$clog2(MAX_WINDOW)-1:0] rd_addr_b,
    output logic [SAMPLE_W-1:0]           rd_data_a,
    output logic [SAMPLE_W-1:0]           rd_data_b
);

    localparam int AW = $clog2(MAX_WINDOW);

    logic [SAMPLE_W-1:0]   mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] valid_reg;
    logic [SAMPLE_W-1:0]   rd_a_reg;
    logic [SAMPLE_W-1:0]   rd_b_reg;
    logic                  rd_a_ok_reg;
    logic                  rd_b_ok_reg;
    logic                  a_in_range;
    logic                  b_in_range;

    assign a_in_range = {1'b0, rd_addr_a} < (AW + 1)'(MAX_WINDOW);
    assign b_in_range = {1'b0, rd_addr_b} < (AW + 1)'(MAX_WINDOW);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    // An entry that was never written since reset or the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_a_ok_reg <= 1'b0;
            rd_b_ok_reg <= 1'b0;
        end
        else
        begin
            if (clr_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_a_ok_reg <= a_in_range && valid_reg[rd_addr_a];
            rd_b_ok_reg <= b_in_range && valid_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_ok_reg ? rd_a_reg : '0;
    assign rd_data_b = rd_b_ok_reg ? rd_b_reg : '0;

endmodule

[sv/smf_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module smf_seq
    import smf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_fire,
    input  dp_status_t status,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_IN:     take = !in_fire;
            COND_IS_CLEAR:  take = status.is_clear;
            COND_WP_GE_WIN: take = status.wp_ge_win;
            COND_J_LT_N:    take = status.j_lt_n;
            COND_I_MORE:    take = status.i_more;
            COND_OUT_WAIT:  take = !out_fire;
            default:        take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[sv/smf_dp.sv]
// Datapath: write position, fill count, rank counting, median selection and averaging.
`include "sliding_median_filter_core_defines.svh"

module smf_dp
    import smf_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_word_t                    ctrl,
    input  logic                          in_fire,
    input  logic                          in_op,
    input  logic [SAMPLE_W-1:0]           in_sample,
    input  logic [WIN_CFG_W-1:0]          win_len_cfg,
    input  logic signed [SAMPLE_W-1:0]    rd_data_a,
    input  logic signed [SAMPLE_W-1:0]    rd_data_b,
    output dp_status_t                    status,
    output logic                          wr_en,
    output logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
    output logic [SAMPLE_W-1:0]           wr_data,
    output logic                          clr_all,
    output logic [$clog2(MAX_WINDOW)-1:0] rd_addr_a,
    output logic [$clog2(MAX_WINDOW)-1:0] rd_addr_b,
    output logic [SAMPLE_W-1:0]           median_value,
    output logic [HELD_W-1:0]             samples_held
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int JW = $clog2(MAX_WINDOW + 2);

    logic                       op_reg;
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [CW-1:0]              wp_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              less_reg;
    logic [CW-1:0]              le_reg;
    logic [JW-1:0]              j_reg;
    logic signed [SAMPLE_W-1:0] cand_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic [SAMPLE_W-1:0]        median_reg;

    logic [CW-1:0]              win;
    logic [JW-1:0]              j_plus1;
    logic                       lane_b_en;
    logic                       lt_a;
    logic                       lt_b;
    logic                       le_a;
    logic                       le_b;
    logic [CW-1:0]              less_add;
    logic [CW-1:0]              le_add;
    logic [CW-1:0]              k_lo;
    logic [CW-1:0]              k_hi;
    logic                       sel_lo;
    logic                       sel_hi;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W:0]   half;
    logic [SAMPLE_W-1:0]        avg;

    always_comb
    begin
        if (win_len_cfg == '0 || win_len_cfg > WIN_CFG_W'(MAX_WINDOW))
        begin
            win = CW'(WIN_FALLBACK);
        end
        else
        begin
            win = CW'(win_len_cfg);
        end
    end

    // Lane A holds entry j-2 and lane B entry j-1; lane A is always inside the held range.
    assign j_plus1   = j_reg + JW'(1);
    assign lane_b_en = j_reg <= JW'(fill_reg);
    assign lt_a      = rd_data_a < cand_reg;
    assign lt_b      = (rd_data_b < cand_reg) && lane_b_en;
    assign le_a      = rd_data_a <= cand_reg;
    assign le_b      = (rd_data_b <= cand_reg) && lane_b_en;
    assign less_add  = CW'(lt_a) + CW'(lt_b);
    assign le_add    = CW'(le_a) + CW'(le_b);

    // The candidate sits at sorted rank k when fewer than k+1 entries are below it
    // and more than k entries are at or below it.
    assign k_hi   = fill_reg >> 1;
    assign k_lo   = (fill_reg - CW'(1)) >> 1;
    assign sel_lo = (less_reg <= k_lo) && (k_lo < le_reg);
    assign sel_hi = (less_reg <= k_hi) && (k_hi < le_reg);

    // The arithmetic shift rounds down, so an odd negative sum is corrected upward to round toward zero.
    assign sum  = {lo_reg[SAMPLE_W-1], lo_reg} + {hi_reg[SAMPLE_W-1], hi_reg};
    assign half = sum >>> 1;
    assign avg  = half[SAMPLE_W-1:0] + SAMPLE_W'(sum[SAMPLE_W] & sum[0]);

    assign status.is_clear  = op_reg == OP_CLEAR;
    assign status.wp_ge_win = wp_reg >= win;
    assign status.j_lt_n    = j_reg < JW'(fill_reg);
    assign status.i_more    = ({1'b0, i_reg} + (CW + 1)'(1)) < {1'b0, fill_reg};

    assign wr_en     = (ctrl.op == DP_APPLY) && (op_reg == OP_PUSH);
    assign clr_all   = (ctrl.op == DP_APPLY) && (op_reg == OP_CLEAR);
    assign wr_addr   = wp_reg[AW-1:0];
    assign wr_data   = sample_reg;
    assign rd_addr_a = (ctrl.op == DP_CAND) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign rd_addr_b = j_plus1[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            less_reg <= '0;
            le_reg   <= '0;
        end
        else
        begin
            unique case (ctrl.op)
                DP_APPLY:
                begin
                    if (op_reg == OP_CLEAR)
                    begin
                        wp_reg   <= '0;
                        fill_reg <= '0;
                    end
                    else
                    begin
                        wp_reg <= wp_reg + CW'(1);
                        if (fill_reg < win)
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                    end
                    i_reg <= '0;
                end
                DP_WRAP:
                begin
                    if (status.wp_ge_win)
                    begin
                        wp_reg <= wp_reg - win;
                    end
                end
                DP_CAND:
                begin
                    j_reg    <= '0;
                    less_reg <= '0;
                    le_reg   <= '0;
                end
                DP_FIRST:
                begin
                    j_reg <= JW'(2);
                end
                DP_COUNT:
                begin
                    less_reg <= less_reg + less_add;
                    le_reg   <= le_reg + le_add;
                    if (status.j_lt_n)
                    begin
                        j_reg <= j_reg + JW'(2);
                    end
                end
                DP_SELECT:
                begin
                    i_reg <= i_reg + CW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            DP_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg     <= in_op;
                    sample_reg <= in_sample;
                end
            end
            DP_APPLY:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    median_reg <= '0;
                end
            end
            DP_FIRST:
            begin
                cand_reg <= rd_data_a;
            end
            DP_SELECT:
            begin
                if (sel_lo)
                begin
                    lo_reg <= cand_reg;
                end
                if (sel_hi)
                begin
                    hi_reg <= cand_reg;
                end
            end
            DP_AVERAGE:
            begin
                median_reg <= avg;
            end
            default:
            begin
            end
        endcase
    end

    assign median_value = median_reg;
    assign samples_held = HELD_W'(fill_reg);

    `SMF_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CW'(MAX_WINDOW), "fill count exceeds the window limit")
    `SMF_ASSERT_IMPLY(a_wp_wrapped, ctrl.op == DP_CAND, wp_reg < win, "write position not wrapped into the window")
    `SMF_ASSERT_IMPLY(a_mid_order, ctrl.op == DP_AVERAGE, lo_reg <= hi_reg, "lower middle value above upper middle value")

endmodule

[tb/smf_median_checker.sv]
// Checker for the sliding median filter: watches the streams and predicts each result.
`timescale 1ns / 1ps

module smf_median_checker
    import smf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [WIN_CFG_W-1:0]   cfg_wr_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output int                     pending,
    output int                     mismatches
);

    localparam int PRINT_CAP = 100;

    typedef struct {
        logic [SAMPLE_W-1:0] median;
        logic [HELD_W-1:0]   held;
    } median_result_t;

    logic signed [SAMPLE_W-1:0] window_q [MAX_WINDOW_DEF];
    int unsigned                wr_pos;
    int unsigned                held_cnt;
    logic [WIN_CFG_W-1:0]       win_cfg;
    median_result_t             expected_medians [$];

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("[%0t] median mismatch: %s", $time, msg);
        end
    endtask

    function automatic int unsigned active_window();
        if (win_cfg == '0 || win_cfg > MAX_WINDOW_DEF)
        begin
            return WIN_FALLBACK;
        end
        return win_cfg;
    endfunction

    // Sorts the held entries and picks the middle one, or averages the middle
    // pair at 33 bits with truncation toward zero.
    function automatic logic [SAMPLE_W-1:0] median_of_window();
        logic signed [SAMPLE_W-1:0] sorted [MAX_WINDOW_DEF];
        logic signed [SAMPLE_W-1:0] key;
        logic signed [SAMPLE_W:0]   pair_sum;
        int n;
        int i;
        int j;
        n = (held_cnt > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : held_cnt;
        if (n == 0)
        begin
            return '0;
        end
        for (i = 0; i < n; i++)
        begin
            sorted[i] = window_q[i];
        end
        for (i = 1; i < n; i++)
        begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        if (n % 2 == 1)
        begin
            return sorted[n/2];
        end
        pair_sum = sorted[n/2-1] + sorted[n/2];
        return SAMPLE_W'(pair_sum / 2);
    endfunction

    function automatic median_result_t absorb_item(input logic op,
                                                   input logic [SAMPLE_W-1:0] smp);
        median_result_t r;
        int unsigned win;
        int unsigned pos;
        if (op == OP_CLEAR)
        begin
            foreach (window_q[k])
            begin
                window_q[k] = '0;
            end
            wr_pos   = 0;
            held_cnt = 0;
            r.median = '0;
        end
        else
        begin
            win = active_window();
            pos = wr_pos % MAX_WINDOW_DEF;
            window_q[pos] = smp;
            // A position left beyond a shrunk window still writes, then wraps.
            wr_pos = (pos + 1) % win;
            if (held_cnt < win)
            begin
                held_cnt++;
            end
            r.median = median_of_window();
        end
        r.held = held_cnt[HELD_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        median_result_t due;
        if (!rst_n)
        begin
            foreach (window_q[k])
            begin
                window_q[k] = '0;
            end
            wr_pos   = 0;
            held_cnt = 0;
            win_cfg  = WIN_FALLBACK;
            expected_medians.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                win_cfg = cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_medians.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result 0x%h", m_axis_tdata));
                end
                else
                begin
                    due = expected_medians.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== due.median)
                    begin
                        report_mismatch($sformatf("median_value got %0d, want %0d",
                            $signed(m_axis_tdata[SAMPLE_W-1:0]), $signed(due.median)));
                    end
                    if (m_axis_tdata[SAMPLE_W +: HELD_W] !== due.held)
                    begin
                        report_mismatch($sformatf("samples_held got %0d, want %0d",
                            m_axis_tdata[SAMPLE_W +: HELD_W], due.held));
                    end
                    if (m_axis_tdata[OUT_TDATA_W-1 -: TDATA_PAD_W] !== '0)
                    begin
                        report_mismatch($sformatf("padding bits not zero: 0x%h",
                            m_axis_tdata[OUT_TDATA_W-1 -: TDATA_PAD_W]));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_medians.push_back(absorb_item(s_axis_tuser,
                                                       s_axis_tdata[SAMPLE_W-1:0]));
            end
            pending <= expected_medians.size();
        end
    end

endmodule

[tb/tb_sliding_median_filter_core.sv]
// Testbench top for the sliding median filter core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sliding_median_filter_core
    import smf_pkg::*;
();

    localparam int  ITEM_TARGET  = 850;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  SETTLE       = 4;
    localparam int  TAIL         = 200;
    localparam int  HOLD_AFTER   = 300;
    localparam int  HOLD_CYCLES  = 600;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [WIN_CFG_W-1:0]   cfg_wr_data   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = OP_PUSH;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int pending;
    int mismatches;
    int items_sent    = 0;
    int burst_left    = 4;
    bit steady_sender = 1'b1;
    int cycle_count   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_median_filter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    smf_median_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .pending       (pending),
        .mismatches    (mismatches)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offers one item and returns at the step of its transfer. tvalid stays high
    // unless the burst or the phase ends there.
    task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] smp,
                             input bit phase_end);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (phase_end)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!steady_sender && burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    // The window may change only once every transfer has its result and the
    // block has gone back to waiting for input.
    task automatic write_window(input logic [WIN_CFG_W-1:0] win);
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= win;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 20) - 10;
            7:             return $urandom_range(0, 3);
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h8000_0001;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h7FFF_FFFE;
                    4:       return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [WIN_CFG_W-1:0] pick_window();
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return WIN_CFG_W'($urandom_range(17, 254));
            3:       return 8'd1;
            4:       return 8'd16;
            5:       return 8'd2;
            default: return WIN_CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    // The receiver switches between always ready, coin flips, a fixed stride
    // and mostly ready. Once, well into the run, it holds off long enough to
    // back the block up into its input.
    initial
    begin : receiver
        int mode;
        int span_left;
        int stride;
        int results_taken;
        bit hold_done;
        mode          = 0;
        span_left     = 0;
        stride        = 2;
        results_taken = 0;
        hold_done     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_taken++;
            end
            if (!hold_done && results_taken >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    stride    = $urandom_range(2, 6);
                    span_left = $urandom_range(50, 400);
                end
                span_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (span_left % stride) == 0;
                    default: m_axis_tready <= $urandom_range(0, 3) != 0;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int k;
        logic op;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of three: the largest pair must average without overflow.
        send_item(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        send_item(OP_PUSH, 32'h8000_0000, 1'b0);
        send_item(OP_CLEAR, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_PUSH, 32'h8000_0000, 1'b0);
        send_item(OP_PUSH, 32'h8000_0000, 1'b0);
        send_item(OP_CLEAR, 32'h0000_0000, 1'b0);
        // A mean of minus one half truncates toward zero.
        send_item(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_PUSH, 32'h0000_0000, 1'b1);

        write_window(8'd4);
        send_item(OP_PUSH, 32'hFFFF_FFFD, 1'b0);
        send_item(OP_PUSH, 32'h5555_5555, 1'b0);
        send_item(OP_PUSH, 32'hAAAA_AAAA, 1'b1);

        // Grow to the full window, then shrink while the history is filled
        // so the write position sits beyond the new window.
        write_window(8'd16);
        for (k = 0; k < 6; k++)
        begin
            send_item(OP_PUSH, $urandom, k == 5);
        end
        write_window(8'd2);
        send_item(OP_PUSH, $urandom, 1'b0);
        send_item(OP_PUSH, $urandom, 1'b1);

        // Out-of-range windows fall back to three.
        write_window(8'd0);
        send_item(OP_PUSH, $urandom, 1'b1);
        write_window(8'd255);
        send_item(OP_PUSH, $urandom, 1'b1);
        write_window(8'd17);
        send_item(OP_PUSH, $urandom, 1'b1);
        write_window(8'd1);
        send_item(OP_CLEAR, $urandom, 1'b0);
        send_item(OP_PUSH, $urandom, 1'b1);
        // Growing after a clear pulls never-written zero entries into the count.
        write_window(8'd16);
        send_item(OP_PUSH, $urandom, 1'b0);
        send_item(OP_PUSH, $urandom, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            write_window(pick_window());
            steady_sender = ($urandom_range(0, 3) == 0);
            burst_left    = $urandom_range(0, 12);
            n = $urandom_range(8, 60);
            for (k = 0; k < n; k++)
            begin
                op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_PUSH;
                send_item(op, pick_sample(), k == n - 1);
            end
        end

        do @(posedge clk); while (pending != 0);
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
